FILE: rtl/mipmap_box_reducer_assert.svh
// Assertion macros shared by the mip level reducer RTL.
// Depends on nothing; included by the top level.
`ifndef MIPMAP_BOX_REDUCER_ASSERT_SVH
`define MIPMAP_BOX_REDUCER_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define MBR_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition holds in the cycle after the trigger.
`define MBR_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

FILE: rtl/mbr_pkg.sv
// Shared types and constants of the mip level reducer.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package mbr_pkg;

    localparam int MAX_SOURCE_HEIGHT = 1024;
    localparam int H_BITS = 11;
    localparam int R_BITS = 10;
    localparam int CFG_BITS = 11;

    localparam logic [1:0] MODE_PLAIN  = 2'd0;
    localparam logic [1:0] MODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_FILL   = 2'd2;

    localparam logic [1:0] REG_SOURCE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SOURCE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_REDUCE_MODE   = 2'd2;

    localparam int ROOT_STEPS = 11;
    localparam int DIV_STEPS = 7;
    localparam int STEP_BITS = 4;

    localparam logic [7:0] ZERO_RG = 8'd191;
    localparam logic [7:0] ZERO_B  = 8'd255;
    localparam logic [7:0] FULL_A  = 8'd255;
    localparam logic [7:0] CENTER  = 8'd128;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_VEC,
        S_SQR,
        S_ROOT_INIT,
        S_ROOT,
        S_DIV_INIT,
        S_DIV,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic load_sum;
        logic vec;
        logic sqr;
        logic root_init;
        logic root_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic normal;
        logic root_done;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

FILE: rtl/mbr_ctrl.sv
// Sequencer of the mip level reducer: steps one source pixel through the datapath.
// Depends on mbr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mbr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire mbr_pkg::status_t st,
    output mbr_pkg::cmd_t        cmd,
    output logic                 in_ready
);
    import mbr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (!st.emit)
                begin
                    state_next = S_IDLE;
                end
                else if (st.normal)
                begin
                    state_next = S_VEC;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end
            S_VEC:       state_next = S_SQR;
            S_SQR:       state_next = S_ROOT_INIT;
            S_ROOT_INIT: state_next = S_ROOT;
            S_ROOT:
            begin
                if (st.root_done)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:  state_next = S_DIV;
            S_DIV:
            begin
                if (st.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.accept = in_valid;
            end
            S_SUM:       cmd.load_sum = 1'b1;
            S_VEC:       cmd.vec = 1'b1;
            S_SQR:       cmd.sqr = 1'b1;
            S_ROOT_INIT: cmd.root_init = 1'b1;
            S_ROOT:      cmd.root_step = 1'b1;
            S_DIV_INIT:  cmd.div_init = 1'b1;
            S_DIV:       cmd.div_step = 1'b1;
            S_EMIT:      cmd.out_load = st.out_free;
            default:     cmd = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/mbr_datapath.sv
// Datapath of the mip level reducer: counters, line buffer, root and divide units.
// Depends on mbr_pkg; driven by mbr_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module mbr_datapath #(
    parameter int MAX_SOURCE_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire mbr_pkg::cmd_t                cmd,
    output mbr_pkg::status_t                  st,
    input  wire logic                         cfg_write,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [mbr_pkg::CFG_BITS-1:0] cfg_data,
    input  wire logic [31:0]                  pixel,
    output logic [31:0]                       mip_pixel,
    output logic                              frame_last,
    output logic                              out_valid,
    input  wire logic                         out_ready
);
    import mbr_pkg::*;

    localparam int PAIR_DEPTH = MAX_SOURCE_WIDTH / 2;
    localparam int C_BITS = $clog2(MAX_SOURCE_WIDTH);
    localparam int X_BITS = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int W_BITS = $clog2(MAX_SOURCE_WIDTH + 1);

    logic [CFG_BITS-1:0] source_width_reg;
    logic [CFG_BITS-1:0] source_height_reg;
    logic [1:0]          reduce_mode_reg;
    logic [C_BITS-1:0]   column_reg;
    logic [R_BITS-1:0]   row_reg;
    logic [31:0]         hold_reg;

    logic [W_BITS-1:0]   w;
    logic [H_BITS-1:0]   h;
    logic                wide;
    logic                tall;
    logic [W_BITS-1:0]   mw;
    logic [H_BITS-1:0]   mh;
    logic [X_BITS-1:0]   x_now;
    logic [R_BITS-1:0]   y_now;
    logic                have;
    logic                wr_en;
    logic                emit_now;
    logic [35:0]         entry;
    logic [8:0]          u_now [4];

    logic [8:0]          u_reg [4];
    logic                emit_reg;
    logic                tall_reg;
    logic                wide_reg;
    logic                last_reg;
    logic [7:0]          fill_reg;
    logic [35:0]         rd_data_reg;
    logic [35:0]         line_mem [PAIR_DEPTH];

    logic [9:0]          tot_reg [4];
    logic signed [10:0]  v_reg [3];
    logic [19:0]         sqv_reg [3];
    logic [21:0]         rem_reg;
    logic [21:0]         res_reg;
    logic [21:0]         bit_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [16:0]         num_reg [3];
    logic [6:0]          q_reg [3];

    logic [31:0]         out_data_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    always_comb
    begin
        if (source_width_reg == '0)
        begin
            w = W_BITS'(1);
        end
        else if (32'(source_width_reg) > 32'(MAX_SOURCE_WIDTH))
        begin
            w = W_BITS'(MAX_SOURCE_WIDTH);
        end
        else
        begin
            w = W_BITS'(source_width_reg);
        end
        if (source_height_reg == '0)
        begin
            h = H_BITS'(1);
        end
        else if (32'(source_height_reg) > 32'(MAX_SOURCE_HEIGHT))
        begin
            h = H_BITS'(MAX_SOURCE_HEIGHT);
        end
        else
        begin
            h = source_height_reg;
        end
    end

    assign wide  = w >= W_BITS'(2);
    assign tall  = h >= H_BITS'(2);
    assign mw    = wide ? (w >> 1) : W_BITS'(1);
    assign mh    = tall ? (h >> 1) : H_BITS'(1);
    assign x_now = X_BITS'(column_reg >> 1);
    assign y_now = tall ? (row_reg >> 1) : '0;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            u_now[i] = wide ? (9'(hold_reg[8*i +: 8]) + 9'(pixel[8*i +: 8]))
                            : 9'(pixel[8*i +: 8]);
        end
        if (wide)
        begin
            have = (W_BITS'(column_reg) < {w[W_BITS-1:1], 1'b0}) && column_reg[0];
        end
        else
        begin
            have = column_reg == '0;
        end
        wr_en = 1'b0;
        emit_now = 1'b0;
        if (have)
        begin
            if (!tall)
            begin
                emit_now = 1'b1;
            end
            else if (H_BITS'(row_reg) < {h[H_BITS-1:1], 1'b0})
            begin
                wr_en = !row_reg[0];
                emit_now = row_reg[0];
            end
        end
        entry = {u_now[3], u_now[2], u_now[1], u_now[0]};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
        begin
            line_mem[x_now] <= entry;
        end
        if (cmd.accept)
        begin
            rd_data_reg <= line_mem[x_now];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_width_reg <= CFG_BITS'(1);
            source_height_reg <= CFG_BITS'(1);
            reduce_mode_reg <= MODE_PLAIN;
            column_reg <= '0;
            row_reg <= '0;
            hold_reg <= '0;
            emit_reg <= 1'b0;
        end
        else if (cfg_write && (cfg_index == REG_SOURCE_WIDTH ||
                               cfg_index == REG_SOURCE_HEIGHT ||
                               cfg_index == REG_REDUCE_MODE))
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  source_width_reg <= cfg_data;
                REG_SOURCE_HEIGHT: source_height_reg <= cfg_data;
                REG_REDUCE_MODE:   reduce_mode_reg <= cfg_data[1:0];
                default:           reduce_mode_reg <= reduce_mode_reg;
            endcase
            column_reg <= '0;
            row_reg <= '0;
            hold_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (wide && !column_reg[0] &&
                (W_BITS'(column_reg) < {w[W_BITS-1:1], 1'b0}))
            begin
                hold_reg <= pixel;
            end
            if (W_BITS'(column_reg) + W_BITS'(1) >= w)
            begin
                column_reg <= '0;
                row_reg <= (H_BITS'(row_reg) + H_BITS'(1) >= h) ? '0 : row_reg + R_BITS'(1);
            end
            else
            begin
                column_reg <= column_reg + C_BITS'(1);
            end
            emit_reg <= emit_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            u_reg <= u_now;
            tall_reg <= tall;
            wide_reg <= wide;
            fill_reg <= 8'(mw);
            last_reg <= (W_BITS'(x_now) == mw - W_BITS'(1)) &&
                        (H_BITS'(y_now) == mh - H_BITS'(1));
        end
        if (cmd.load_sum)
        begin
            for (int i = 0; i < 4; i++)
            begin
                tot_reg[i] <= tall_reg ? (10'(rd_data_reg[9*i +: 9]) + 10'(u_reg[i]))
                                       : {u_reg[i], 1'b0};
            end
        end
        if (cmd.vec)
        begin
            for (int i = 0; i < 3; i++)
            begin
                v_reg[i] <= $signed({1'b0, tot_reg[i]}) -
                            (wide_reg ? 11'sd508 : 11'sd254);
            end
        end
        if (cmd.sqr)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sqv_reg[i] <= 20'(v_reg[i]) * 20'(v_reg[i]);
            end
        end
        if (cmd.root_init)
        begin
            rem_reg <= 22'(sqv_reg[0]) + 22'(sqv_reg[1]) + 22'(sqv_reg[2]);
            res_reg <= '0;
            bit_reg <= 22'(1) << 20;
            step_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            if (rem_reg >= res_reg + bit_reg)
            begin
                rem_reg <= rem_reg - (res_reg + bit_reg);
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
            step_reg <= step_reg + STEP_BITS'(1);
        end
        else if (cmd.div_init)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (17'(v_reg[i][10] ? -v_reg[i] : v_reg[i]) << 7) -
                              17'(v_reg[i][10] ? -v_reg[i] : v_reg[i]);
                q_reg[i] <= '0;
            end
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (num_reg[i] >= (17'(res_reg[9:0]) << (3'(DIV_STEPS - 1) - step_reg[2:0])))
                begin
                    num_reg[i] <= num_reg[i] -
                                  (17'(res_reg[9:0]) << (3'(DIV_STEPS - 1) - step_reg[2:0]));
                    q_reg[i] <= {q_reg[i][5:0], 1'b1};
                end
                else
                begin
                    q_reg[i] <= {q_reg[i][5:0], 1'b0};
                end
            end
            step_reg <= step_reg + STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_last_reg <= last_reg;
            if (reduce_mode_reg == MODE_FILL)
            begin
                out_data_reg <= {fill_reg, fill_reg, fill_reg, fill_reg};
            end
            else if (reduce_mode_reg == MODE_NORMAL)
            begin
                if (res_reg == '0)
                begin
                    out_data_reg <= {FULL_A, ZERO_B, ZERO_RG, ZERO_RG};
                end
                else
                begin
                    out_data_reg[31:24] <= FULL_A;
                    for (int i = 0; i < 3; i++)
                    begin
                        out_data_reg[8*i +: 8] <= v_reg[i][10] ? (CENTER - 8'(q_reg[i]))
                                                               : (CENTER + 8'(q_reg[i]));
                    end
                end
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    out_data_reg[8*i +: 8] <= wide_reg ? tot_reg[i][9:2] : tot_reg[i][8:1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        st.emit      = emit_reg;
        st.normal    = reduce_mode_reg == MODE_NORMAL;
        st.root_done = step_reg == STEP_BITS'(ROOT_STEPS - 1);
        st.div_done  = step_reg == STEP_BITS'(DIV_STEPS - 1);
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign mip_pixel  = out_data_reg;
    assign frame_last = out_last_reg;
    assign out_valid  = out_valid_reg;

endmodule

`default_nettype wire

FILE: rtl/mipmap_box_reducer.sv
// Channel     | Signals                              | Content
// s_axis      | s_axis_tvalid/tready/tdata           | source RGBA pixel, raster order
// m_axis      | m_axis_tvalid/tready/tdata/tlast     | reduced RGBA pixel, tlast on level end
// cfg         | cfg_valid/ready/index/data           | source_width, source_height, reduce_mode
// A pixel that completes no block is only summed; one that does goes to the output in plain
// and fill mode, and in normal-map mode after the 11-step root and 7-step divide units.
// A finished pixel waits in the output register while the next source pixel is taken.
// Reset clears counters, configuration and control state; the line buffer needs no clearing.
// Configuration writes are always taken; those to the three registers restart the level.
`timescale 1ns / 1ps
`default_nettype none
`include "mipmap_box_reducer_assert.svh"

module mipmap_box_reducer #(
    parameter int MAX_SOURCE_WIDTH = 1024
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // pixel_red, pixel_green, pixel_blue, pixel_alpha from bit 0 up.
    input  wire logic [31:0]                  s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // mip_red, mip_green, mip_blue, mip_alpha from bit 0 up.
    output logic [31:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [mbr_pkg::CFG_BITS-1:0] cfg_data
);
    import mbr_pkg::*;

    cmd_t    cmd;
    status_t st;

    assign cfg_ready = 1'b1;

    mbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .st       (st),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    mbr_datapath #(
        .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .cfg_write  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pixel      (s_axis_tdata),
        .mip_pixel  (m_axis_tdata),
        .frame_last (m_axis_tlast),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready)
    );

    `MBR_ASSERT_NEXT(a_busy_after_transfer, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while busy")
    `MBR_ASSERT_NEXT(a_out_from_load, clk, rst_n, cmd.out_load, m_axis_tvalid, "loaded result not shown")
    `MBR_ASSERT_SAME(a_load_needs_room, clk, rst_n, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwritten")

endmodule

`default_nettype wire
